@@ sv/gapc_pkg.sv @@
// ----------------------------------------------------------------------------
// gapc_pkg
// Shared types and constants of the gear actuator position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gapc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ERR_BITS    = SAMPLE_BITS + 1;
    // wide enough for idle +/- 4*tol, 2*sample, and error differences
    localparam int CMP_W       = ((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18) + 2;

    localparam int GAIN_BITS   = 8;
    localparam int BIAS_BITS   = 8;
    localparam int COUNT_BITS  = 10;
    localparam int TOL_BITS    = 15;
    localparam int BAND_SHIFT  = 2;
    localparam int SUM_W       = ERR_BITS + GAIN_BITS + 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [7:0]            DRIVE_MAX   = 8'd255;
    localparam logic signed [CMP_W-1:0] CHANGE_LIMIT = CMP_W'(10);

    localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 8 + ERR_BITS + 2 + 2 + 2 + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_DATA_W = (SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_POS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_POS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SET_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd7;

    // target select and gear codes
    localparam logic [1:0] SEL_IDLE   = 2'd0;
    localparam logic [1:0] SEL_FIRST  = 2'd1;
    localparam logic [1:0] SEL_SECOND = 2'd2;
    localparam logic [1:0] SEL_DIRECT = 2'd3;

    // band codes
    localparam logic [1:0] BAND_NEUTRAL = 2'd0;
    localparam logic [1:0] BAND_LOW     = 2'd1;
    localparam logic [1:0] BAND_HIGH    = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] idle_pos;
        logic signed [SAMPLE_BITS-1:0] first_pos;
        logic signed [SAMPLE_BITS-1:0] second_pos;
        logic [GAIN_BITS-1:0]          gain;
        logic [BIAS_BITS-1:0]          bias;
        logic [COUNT_BITS-1:0]         set_limit;
        logic [COUNT_BITS-1:0]         clear_limit;
        logic [TOL_BITS-1:0]           tolerance;
    } cfg_t;

    // per-word results of the datapath handed to the stall tracker
    typedef struct packed {
        logic [1:0]                    sel;
        logic [SAMPLE_BITS-1:0]        target;
        logic signed [ERR_BITS-1:0]    err;
        logic [7:0]                    drive;
        logic                          reached;
    } ctrl_t;

    typedef struct packed {
        logic [7:0] drive;
        logic [1:0] engaged;
        logic       stuck;
    } status_t;

endpackage

`default_nettype wire

@@ sv/gapc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gapc_cfg_regs
// Configuration register file with reset values, written one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module gapc_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gapc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gapc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output gapc_pkg::cfg_t                         cfg
);
    import gapc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_IDLE_POS:    cfg_next.idle_pos    = cfg_data[SAMPLE_BITS-1:0];
                REG_FIRST_POS:   cfg_next.first_pos   = cfg_data[SAMPLE_BITS-1:0];
                REG_SECOND_POS:  cfg_next.second_pos  = cfg_data[SAMPLE_BITS-1:0];
                REG_GAIN:        cfg_next.gain        = cfg_data[GAIN_BITS-1:0];
                REG_BIAS:        cfg_next.bias        = cfg_data[BIAS_BITS-1:0];
                REG_SET_LIMIT:   cfg_next.set_limit   = cfg_data[COUNT_BITS-1:0];
                REG_CLEAR_LIMIT: cfg_next.clear_limit = cfg_data[COUNT_BITS-1:0];
                REG_TOLERANCE:   cfg_next.tolerance   = cfg_data[TOL_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_pos    <= '0;
            cfg_reg.first_pos   <= '0;
            cfg_reg.second_pos  <= '0;
            cfg_reg.gain        <= GAIN_BITS'(179);
            cfg_reg.bias        <= BIAS_BITS'(128);
            cfg_reg.set_limit   <= COUNT_BITS'(300);
            cfg_reg.clear_limit <= COUNT_BITS'(200);
            cfg_reg.tolerance   <= TOL_BITS'(50);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/gapc_datapath.sv @@
// ----------------------------------------------------------------------------
// gapc_datapath
// Target selection, error, proportional drive and band classification.
// ----------------------------------------------------------------------------
`default_nettype none

module gapc_datapath (
    input  wire gapc_pkg::cfg_t                     cfg,
    input  wire logic signed [gapc_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [1:0]                         target_select,
    input  wire logic signed [gapc_pkg::SAMPLE_BITS-1:0] direct_target,
    output gapc_pkg::ctrl_t                         ctrl,
    output logic [1:0]                              closest_band,
    output logic [1:0]                              gear_zone
);
    import gapc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] target;
    logic signed [ERR_BITS-1:0]    err;
    logic signed [SUM_W-1:0]       sum;
    logic [7:0]                    drive;
    logic signed [CMP_W-1:0]       x_e;
    logic signed [CMP_W-1:0]       idle_e;
    logic signed [CMP_W-1:0]       tol_e;
    logic signed [CMP_W-1:0]       band_e;
    logic signed [CMP_W-1:0]       err_e;
    logic signed [CMP_W-1:0]       x2_e;
    logic signed [CMP_W-1:0]       hi_split;
    logic signed [CMP_W-1:0]       lo_split;

    always_comb begin
        case (target_select)
            SEL_IDLE:   target = cfg.idle_pos;
            SEL_FIRST:  target = cfg.first_pos;
            SEL_SECOND: target = cfg.second_pos;
            default:    target = direct_target;
        endcase
    end

    assign err = ERR_BITS'(target) - ERR_BITS'(sample);

    // gain is Q0.8, bias sits in the integer byte of the sum
    assign sum = $signed({1'b0, cfg.gain}) * SUM_W'(err)
               + $signed(SUM_W'({cfg.bias, 8'h00}));

    always_comb begin
        if (sum < 0) begin
            drive = '0;
        end else if (|sum[SUM_W-2:16]) begin
            drive = DRIVE_MAX;
        end else begin
            drive = sum[15:8];
        end
    end

    assign x_e    = CMP_W'(sample);
    assign idle_e = CMP_W'(cfg.idle_pos);
    assign tol_e  = $signed(CMP_W'(cfg.tolerance));
    assign band_e = tol_e <<< BAND_SHIFT;
    assign err_e  = CMP_W'(err);

    always_comb begin
        if (x_e > idle_e + band_e) begin
            closest_band = BAND_HIGH;
        end else if (x_e < idle_e - band_e) begin
            closest_band = BAND_LOW;
        end else begin
            closest_band = BAND_NEUTRAL;
        end
    end

    // half-way points compared at twice the scale
    assign x2_e     = x_e <<< 1;
    assign hi_split = CMP_W'(cfg.second_pos) + idle_e;
    assign lo_split = idle_e + CMP_W'(cfg.first_pos);

    always_comb begin
        if (x2_e > hi_split) begin
            gear_zone = SEL_SECOND;
        end else if (x2_e < lo_split) begin
            gear_zone = SEL_FIRST;
        end else begin
            gear_zone = SEL_IDLE;
        end
    end

    assign ctrl.sel     = target_select;
    assign ctrl.target  = target;
    assign ctrl.err     = err;
    assign ctrl.drive   = drive;
    assign ctrl.reached = (err_e < tol_e) && (-err_e < tol_e);

endmodule

`default_nettype wire

@@ sv/gapc_stall.sv @@
// ----------------------------------------------------------------------------
// gapc_stall
// Stall counter, stuck and pause flags, and latched engaged gear.
// ----------------------------------------------------------------------------
`default_nettype none

module gapc_stall (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       upd,
    input  wire gapc_pkg::cfg_t  cfg,
    input  wire gapc_pkg::ctrl_t ctrl,
    output gapc_pkg::status_t status
);
    import gapc_pkg::*;

    logic signed [ERR_BITS-1:0]  prev_err_reg, prev_err_next;
    logic [SAMPLE_BITS-1:0]      prev_tgt_reg, prev_tgt_next;
    logic [COUNT_BITS-1:0]       cnt_reg, cnt_next;
    logic                        pause_reg, pause_next;
    logic                        stuck_reg, stuck_next;
    logic [1:0]                  eng_reg, eng_next;

    logic signed [CMP_W-1:0]     diff;
    logic                        small_change;
    logic                        tgt_change;
    logic [COUNT_BITS-1:0]       cnt_step;
    logic [COUNT_BITS-1:0]       cnt_mid;
    logic                        pause_mid;
    logic                        stuck_mid;

    assign diff         = CMP_W'(ctrl.err) - CMP_W'(prev_err_reg);
    assign small_change = (diff < CHANGE_LIMIT) && (diff > -CHANGE_LIMIT);
    assign tgt_change   = ctrl.target != prev_tgt_reg;

    always_comb begin
        cnt_step = cnt_reg;
        if (!pause_reg) begin
            if (small_change) begin
                if (cnt_reg != COUNT_MAX) begin
                    cnt_step = cnt_reg + 1'b1;
                end
            end else if (cnt_reg != '0) begin
                cnt_step = cnt_reg - 1'b1;
            end
        end

        cnt_mid   = tgt_change ? '0 : cnt_step;
        pause_mid = tgt_change ? 1'b0 : pause_reg;

        // limits applied as written, set side checked first
        stuck_mid = stuck_reg;
        if (cnt_mid > cfg.set_limit) begin
            stuck_mid = 1'b1;
        end else if (cnt_mid < cfg.clear_limit) begin
            stuck_mid = 1'b0;
            pause_mid = 1'b0;
        end

        cnt_next      = cnt_mid;
        stuck_next    = stuck_mid;
        pause_next    = pause_mid || stuck_mid || ctrl.reached;
        eng_next      = ctrl.reached ? ctrl.sel : eng_reg;
        prev_err_next = ctrl.err;
        prev_tgt_next = ctrl.target;
    end

    assign status.drive   = stuck_next ? cfg.bias : ctrl.drive;
    assign status.engaged = eng_next;
    assign status.stuck   = stuck_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            prev_tgt_reg <= '0;
            cnt_reg      <= '0;
            pause_reg    <= 1'b0;
            stuck_reg    <= 1'b0;
            eng_reg      <= SEL_IDLE;
        end else if (upd) begin
            prev_err_reg <= prev_err_next;
            prev_tgt_reg <= prev_tgt_next;
            cnt_reg      <= cnt_next;
            pause_reg    <= pause_next;
            stuck_reg    <= stuck_next;
            eng_reg      <= eng_next;
        end
    end

    a_stuck_pauses: assert property (@(posedge aclk) disable iff (!aresetn)
        upd && stuck_next |=> pause_reg && stuck_reg)
        else $error("stuck set without pause");

    a_target_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        upd && tgt_change |=> cnt_reg == '0)
        else $error("stall count not cleared on target change");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd |=> $stable(cnt_reg) && $stable(eng_reg) && $stable(prev_err_reg))
        else $error("stall state moved without a word");

    a_reached_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        upd && ctrl.reached |=> pause_reg && eng_reg == $past(ctrl.sel))
        else $error("reached target not latched");

endmodule

`default_nettype wire

@@ sv/gear_actuator_p_control_stall_detect.sv @@
// ----------------------------------------------------------------------------
// gear_actuator_p_control_stall_detect
// Proportional gear actuator position controller with stall detection.
// ----------------------------------------------------------------------------
// Takes one sample word per cycle while m_axis_tready stays high, and returns
// one result word per sample. An accepted word passes through the input
// register, then the result register, which drives m_axis_tvalid. The stall
// and engaged-gear state updates in the single cycle a word moves from the
// input register to the result register, which sets the rate of one word per
// clock when results are not held back. While a result waits on m_axis_tready
// the input register still takes one more word, then s_axis_tready drops until
// the result leaves. Configuration writes are taken at any time, cfg_ready is
// always high; write them only while no word is in flight.
`default_nettype none

module gear_actuator_p_control_stall_detect (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: sample, direct_target
    input  wire logic [gapc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: target_select
    input  wire logic [1:0]                        s_axis_tuser,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: drive, position_error, closest_band, gear_zone, engaged_gear, stuck
    output logic [gapc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gapc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gapc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gapc_pkg::*;

    cfg_t    cfg;
    ctrl_t   ctrl;
    status_t status;

    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic signed [SAMPLE_BITS-1:0] in_direct_reg;
    logic [1:0]                    in_sel_reg;
    logic                          out_valid_reg;
    logic [OUT_DATA_W-1:0]         out_data_reg;
    logic [OUT_DATA_W-1:0]         out_data_next;
    logic [1:0]                    closest_band;
    logic [1:0]                    gear_zone;
    logic                          advance;
    logic                          in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    gapc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gapc_datapath u_dp (
        .cfg           (cfg),
        .sample        (in_sample_reg),
        .target_select (in_sel_reg),
        .direct_target (in_direct_reg),
        .ctrl          (ctrl),
        .closest_band  (closest_band),
        .gear_zone     (gear_zone)
    );

    gapc_stall u_stall (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (advance),
        .cfg     (cfg),
        .ctrl    (ctrl),
        .status  (status)
    );

    assign out_data_next = OUT_DATA_W'({status.stuck, status.engaged, gear_zone,
                                        closest_band, ctrl.err, status.drive});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_direct_reg <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            in_sel_reg    <= s_axis_tuser;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ tb/gear_actuator_p_control_stall_detect_tb.sv @@
// ----------------------------------------------------------------------------
// gear_actuator_p_control_stall_detect_tb
// Self-checking bench for the gear actuator position controller. A per-word
// predictor follows every accepted sample word and checks each result
// word field by field. The bench runs directed corner words, then random
// stall, approach and noise sequences under several register settings, with
// random idle bursts on both streams and one long result back-pressure.
// ----------------------------------------------------------------------------
module gear_actuator_p_control_stall_detect_tb;
    import gapc_pkg::*;

    localparam int          MOVE_THRESHOLD = 10;
    localparam int          COUNT_TOP      = 1023;
    localparam int          LONG_HOLD      = 60;
    localparam int          DRAIN_CYCLES   = 6;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    // result word, lowest bits last
    typedef struct packed {
        logic                       stuck;
        logic [1:0]                 engaged;
        logic [1:0]                 near;
        logic [1:0]                 closest;
        logic signed [ERR_BITS-1:0] error;
        logic [7:0]                 drive;
    } tick_result_t;

    class actuator_scoreboard;
        logic signed [SAMPLE_BITS-1:0] idle_pos, first_pos, second_pos;
        logic [GAIN_BITS-1:0]          gain;
        logic [BIAS_BITS-1:0]          bias;
        logic [COUNT_BITS-1:0]         set_limit, clear_limit;
        logic [TOL_BITS-1:0]           tolerance;
        int                            prev_error;
        logic [SAMPLE_BITS-1:0]        prev_target;
        int                            stall_count;
        bit                            pause_flag, stuck_flag;
        logic [1:0]                    engaged;
        tick_result_t                  expected_ticks[$];
        int unsigned                   errors;

        function new();
            idle_pos    = '0;
            first_pos   = '0;
            second_pos  = '0;
            gain        = 8'd179;
            bias        = 8'd128;
            set_limit   = 10'd300;
            clear_limit = 10'd200;
            tolerance   = 15'd50;
            prev_error  = 0;
            prev_target = '0;
            stall_count = 0;
            pause_flag  = 1'b0;
            stuck_flag  = 1'b0;
            engaged     = SEL_IDLE;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_IDLE_POS:    idle_pos    = value[SAMPLE_BITS-1:0];
                REG_FIRST_POS:   first_pos   = value[SAMPLE_BITS-1:0];
                REG_SECOND_POS:  second_pos  = value[SAMPLE_BITS-1:0];
                REG_GAIN:        gain        = value[GAIN_BITS-1:0];
                REG_BIAS:        bias        = value[BIAS_BITS-1:0];
                REG_SET_LIMIT:   set_limit   = value[COUNT_BITS-1:0];
                REG_CLEAR_LIMIT: clear_limit = value[COUNT_BITS-1:0];
                REG_TOLERANCE:   tolerance   = value[TOL_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int target_for(logic [1:0] sel, logic [SAMPLE_BITS-1:0] direct);
            case (sel)
                SEL_IDLE:   return int'(idle_pos);
                SEL_FIRST:  return int'(first_pos);
                SEL_SECOND: return int'(second_pos);
                default:    return int'($signed(direct));
            endcase
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // one control tick: error, drive, bands, stall tracking, gear latch
        function void take_tick(logic [SAMPLE_BITS-1:0] position, logic [1:0] sel,
                                logic [SAMPLE_BITS-1:0] direct);
            int           x, idle, tgt, err, diff, sum, tol, drv;
            tick_result_t r;
            x    = $signed(position);
            idle = int'(idle_pos);
            tgt  = target_for(sel, direct);
            tol  = int'(tolerance);

            if (x > idle + 4 * tol)
                r.closest = BAND_HIGH;
            else if (x < idle - 4 * tol)
                r.closest = BAND_LOW;
            else
                r.closest = BAND_NEUTRAL;

            if (2 * x > int'(second_pos) + idle)
                r.near = SEL_SECOND;
            else if (2 * x < idle + int'(first_pos))
                r.near = SEL_FIRST;
            else
                r.near = SEL_IDLE;

            err = tgt - x;
            sum = int'(gain) * err + 256 * int'(bias);
            if (sum < 0)
                drv = 0;
            else if ((sum >>> 8) > 255)
                drv = 255;
            else
                drv = sum >>> 8;

            diff = err - prev_error;
            if (diff < 0)
                diff = -diff;
            if (!pause_flag) begin
                if (diff < MOVE_THRESHOLD) begin
                    if (stall_count < COUNT_TOP)
                        stall_count++;
                end else if (stall_count > 0) begin
                    stall_count--;
                end
            end

            if (SAMPLE_BITS'(tgt) != prev_target) begin
                stall_count = 0;
                pause_flag  = 1'b0;
            end

            if (stall_count > int'(set_limit)) begin
                stuck_flag = 1'b1;
            end else if (stall_count < int'(clear_limit)) begin
                stuck_flag = 1'b0;
                pause_flag = 1'b0;
            end

            if (stuck_flag) begin
                drv        = int'(bias);
                pause_flag = 1'b1;
            end

            if (err < tol && -err < tol) begin
                engaged    = sel;
                pause_flag = 1'b1;
            end

            prev_error  = err;
            prev_target = SAMPLE_BITS'(tgt);

            r.drive   = 8'(drv);
            r.error   = ERR_BITS'(err);
            r.engaged = engaged;
            r.stuck   = stuck_flag;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0) begin
                $display("%0t: result word with nothing expected: %h", $time, got);
                errors++;
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("drive", want.drive, got.drive);
            compare_field("position_error", $signed(want.error), $signed(got.error));
            compare_field("closest_band", want.closest, got.closest);
            compare_field("gear_zone", want.near, got.near);
            compare_field("engaged_gear", want.engaged, got.engaged);
            compare_field("stuck", want.stuck, got.stuck);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit                    sender_gaps = 1'b0;
    bit                    receiver_gaps = 1'b0;
    bit                    hold_request = 1'b0;
    int unsigned           cycle_count = 0;
    actuator_scoreboard    board;

    gear_actuator_p_control_stall_detect dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("gear_actuator_p_control_stall_detect verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_word(tick_result_t'(m_axis_tdata));
    end

    // result side pacing: random stall bursts and one long hold on request
    initial begin : result_pacing
        int unsigned span;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(1, 9);
                repeat (span) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // starts and ends at a falling edge; valid stays high unless a gap follows
    task automatic send_tick(input logic [SAMPLE_BITS-1:0] position, input logic [1:0] sel,
                             input logic [SAMPLE_BITS-1:0] direct);
        int unsigned span;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {direct, position};
        s_axis_tuser  <= sel;
        forever begin
            @(posedge aclk);
            if (s_axis_tready)
                break;
        end
        board.take_tick(position, sel, direct);
        @(negedge aclk);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            span = $urandom_range(1, 9);
            repeat (span) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever begin
            @(posedge aclk);
            if (cfg_ready)
                break;
        end
        board.set_reg(idx, value);
        @(negedge aclk);
    endtask

    task automatic load_settings(input int idle, input int first, input int second,
                                 input int gain, input int bias, input int set_lim,
                                 input int clear_lim, input int tol);
        write_reg(REG_IDLE_POS, CFG_DATA_W'(idle));
        write_reg(REG_FIRST_POS, CFG_DATA_W'(first));
        write_reg(REG_SECOND_POS, CFG_DATA_W'(second));
        write_reg(REG_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_BIAS, CFG_DATA_W'(bias));
        write_reg(REG_SET_LIMIT, CFG_DATA_W'(set_lim));
        write_reg(REG_CLEAR_LIMIT, CFG_DATA_W'(clear_lim));
        write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_settings();
        int idle;
        idle = int'($signed(16'($urandom)));
        load_settings(idle, idle - int'($urandom_range(0, 12000)),
                      idle + int'($urandom_range(0, 12000)), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 60),
                      $urandom_range(0, 60), $urandom_range(0, 400));
    endtask

    // same target, sample jittering around one spot
    task automatic stall_run(input int unsigned len, input logic [1:0] sel,
                             input logic [SAMPLE_BITS-1:0] direct,
                             input logic [SAMPLE_BITS-1:0] spot, input int jitter_max);
        repeat (len)
            send_tick(spot + SAMPLE_BITS'(int'($urandom_range(0, 2 * jitter_max)) - jitter_max),
                      sel, direct);
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned sent, run_len, kind;
        logic [1:0]  sel;
        logic [SAMPLE_BITS-1:0] direct;
        int          tgt, offset;
        sent = 0;
        while (sent < count) begin
            kind    = $urandom_range(0, 9);
            sel     = 2'($urandom_range(0, 3));
            direct  = SAMPLE_BITS'($urandom);
            run_len = $urandom_range(4, 40);
            if (run_len > count - sent)
                run_len = count - sent;
            if (kind < 5) begin
                stall_run(run_len, sel, direct, SAMPLE_BITS'($urandom),
                          ($urandom_range(0, 3) == 0) ? 9 : 4);
            end else if (kind < 8) begin
                // converge on the target so the tolerance latch fires
                tgt    = board.target_for(sel, direct);
                offset = int'($urandom_range(0, 8000)) - 4000;
                repeat (run_len) begin
                    send_tick(SAMPLE_BITS'(tgt + offset), sel, direct);
                    offset = offset / 2;
                end
            end else begin
                repeat (run_len)
                    send_tick(SAMPLE_BITS'($urandom), 2'($urandom_range(0, 3)),
                              SAMPLE_BITS'($urandom));
            end
            sent += run_len;
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        board = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;

        // reset settings: positions at zero, tolerance 50
        send_tick(16'd0, SEL_IDLE, 16'd0);
        send_tick(16'h7fff, SEL_IDLE, 16'd0);
        send_tick(16'h8000, SEL_IDLE, 16'd0);
        send_tick(16'h8000, SEL_DIRECT, 16'h7fff);
        send_tick(16'h7fff, SEL_DIRECT, 16'h8000);
        send_tick(16'd200, SEL_FIRST, 16'hffff);
        send_tick(16'd201, SEL_SECOND, 16'h0000);
        send_tick(-16'sd200, SEL_DIRECT, 16'hffff);
        send_tick(-16'sd201, SEL_DIRECT, 16'd0);
        send_tick(16'd1, SEL_DIRECT, 16'd50);
        send_tick(16'd0, SEL_DIRECT, 16'd50);
        send_tick(16'd50, SEL_FIRST, 16'd0);
        send_tick(16'd49, SEL_SECOND, 16'd0);
        send_tick(-16'sd180, SEL_IDLE, 16'd0);
        send_tick(-16'sd184, SEL_IDLE, 16'd0);
        repeat (6) send_tick(16'd1000, SEL_DIRECT, 16'd1400);
        random_phase(80);
        settle();

        load_settings(0, -8000, 8000, 255, 0, 20, 5, 100);
        // long result stall while words keep coming
        hold_request = 1'b1;
        sender_gaps  = 1'b0;
        random_phase(40);
        sender_gaps = 1'b1;
        random_phase(60);
        settle();

        load_settings(-32768, -32768, 32767, 0, 255, 0, 0, 32767);
        random_phase(100);
        settle();

        // tolerance zero never latches, so the count climbs past the set limit
        load_settings(32767, -32768, 32767, 255, 0, 100, 60, 0);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        stall_run(130, SEL_DIRECT, 16'd1200, 16'd1000, 4);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        random_phase(60);
        settle();

        // clear limit above set limit
        load_settings(100, -5000, 5000, 179, 100, 10, 40, 200);
        random_phase(100);
        settle();

        load_random_settings();
        random_phase(100);
        settle();

        load_random_settings();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        random_phase(100);
        settle();

        if (board.errors == 0 && board.pending() == 0)
            $display("gear_actuator_p_control_stall_detect verification clean");
        else
            $display("gear_actuator_p_control_stall_detect verification failed");
        $finish;
    end
endmodule
